[hw/rtl/lgd_pkg.sv]
package lgd_pkg;

  localparam int unsigned NUM_BYTES_DEF = 128;
  localparam int unsigned CMD_DEPTH     = 2;
  localparam int unsigned OUT_DEPTH     = 2;

  localparam logic [7:0]  FRAME_BYTES_RESET = 8'd90;
  localparam logic [11:0] GAMMA_MAX         = 12'd3840;
  localparam logic [7:0]  RESIDUE_STEP      = 8'd157;
  localparam logic [23:0] SYMBOL_BASE       = 24'h924924;

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_GAMMA = 1'b1
  } mode_e;

  // one queued item, byte position travels beside it
  typedef struct packed {
    mode_e       mode;
    logic [7:0]  pixel;
    logic [11:0] entry;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic [23:0] waveform;
    logic [3:0]  level;
    logic        frame_end;
  } res_t;

  typedef struct packed {
    logic clearing;
  } status_t;

  // one 1,bit,0 symbol per level bit; the upper four bits of the byte are zero
  function automatic logic [23:0] expand_level(logic [3:0] lvl);
    logic [23:0] w;
    w = SYMBOL_BASE;
    for (int k = 0; k < 4; k++) begin
      w[3*k+1] = lvl[k];
    end
    return w;
  endfunction

endpackage

[hw/rtl/lgd_ram.sv]
module lgd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/lgd_fifo.sv]
module lgd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [Width-1:0]             data_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output logic [Width-1:0]             data_o,
  output logic                         empty_o,
  output logic [$clog2(Depth+1)-1:0]   count_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastPtr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  DepthC  = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == DepthC);
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[hw/rtl/lgd_front.sv]
module lgd_front #(
  parameter int unsigned NUM_BYTES = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [7:0]                 cfg_frame_bytes_i,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic                       mode_i,
  input  logic [7:0]                 pixel_value_i,
  input  logic [11:0]                gamma_entry_i,
  input  lgd_pkg::status_t           status_i,
  input  logic                       cmd_full_i,
  output logic                       cmd_push_o,
  output lgd_pkg::cmd_t              cmd_o,
  output logic [((NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1)-1:0] cmd_pos_o
);

  import lgd_pkg::*;

  localparam int unsigned PosW = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;
  localparam int unsigned LenW = $clog2(NUM_BYTES + 1);
  localparam int unsigned CmpW = (LenW > 8) ? LenW : 8;
  localparam logic [CmpW-1:0] NumBytesC = CmpW'(NUM_BYTES);

  logic [7:0]      frame_bytes_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [CmpW-1:0] len, fb_ext, pos_inc;
  logic            last, accept;

  assign cfg_ready_o = 1'b1;
  assign full_o      = cmd_full_i | status_i.clearing;
  assign accept      = push_i & ~full_o;
  assign cmd_push_o  = accept;

  always_comb begin
    // clamp the frame length to 1..NUM_BYTES
    fb_ext = CmpW'(frame_bytes_q);
    if (fb_ext == '0) begin
      len = CmpW'(1);
    end else if (fb_ext > NumBytesC) begin
      len = NumBytesC;
    end else begin
      len = fb_ext;
    end
    pos_inc = CmpW'(pos_q) + CmpW'(1);
    last    = (pos_inc >= len);

    pos_d = pos_q;
    if (accept && mode_e'(mode_i) == MODE_PIXEL) begin
      pos_d = last ? '0 : PosW'(pos_inc);
    end

    cmd_o.mode  = mode_e'(mode_i);
    cmd_o.pixel = pixel_value_i;
    cmd_o.entry = (gamma_entry_i > GAMMA_MAX) ? GAMMA_MAX : gamma_entry_i;
    cmd_o.last  = last;
    cmd_pos_o   = pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_bytes_q <= FRAME_BYTES_RESET;
      pos_q         <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        frame_bytes_q <= cfg_frame_bytes_i;
      end
      pos_q <= pos_d;
    end
  end

endmodule

[hw/rtl/lgd_back.sv]
module lgd_back #(
  parameter int unsigned NUM_BYTES = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_empty_i,
  input  lgd_pkg::cmd_t              cmd_i,
  input  logic [((NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1)-1:0] cmd_pos_i,
  output logic                       cmd_pop_o,
  output lgd_pkg::status_t           status_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic [23:0]                waveform_bits_o,
  output logic [3:0]                 level_o,
  output logic                       frame_end_o
);

  import lgd_pkg::*;

  localparam int unsigned PosW = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;
  localparam int unsigned CntW = $clog2(OUT_DEPTH + 1);
  localparam logic [PosW-1:0] LastPos   = PosW'(NUM_BYTES - 1);
  localparam logic [CntW:0]   OutDepthC = (CntW + 1)'(OUT_DEPTH);

  logic            clearing_q, clearing_d;
  logic [PosW-1:0] clr_idx_q, clr_idx_d;
  logic [7:0]      clr_val_q, clr_val_d;

  logic            s1_valid_q, s1_last_q, s1_fwd_q;
  logic [PosW-1:0] s1_pos_q;
  logic [7:0]      last_wr_q;

  logic            can_issue, issue_pix, gamma_we, pop_fire;
  logic [CntW:0]   occ_next;
  logic [11:0]     gamma_rdata;
  logic [7:0]      res_rdata, residue;
  logic [12:0]     sum;
  logic            res_we;
  logic [PosW-1:0] res_waddr;
  logic [7:0]      res_wdata;
  logic            out_full, out_empty;
  logic [CntW-1:0] out_count;
  res_t            res_in, res_out;

  assign status_o.clearing = clearing_q;

  always_comb begin
    pop_fire = pop_i & ~out_empty;
    // results already promised to the output queue, after this cycle's pop
    occ_next = (CntW + 1)'(out_count) - (CntW + 1)'(pop_fire) + (CntW + 1)'(s1_valid_q);
    can_issue = ~clearing_q & ~cmd_empty_i &
                ((cmd_i.mode == MODE_GAMMA) | (occ_next < OutDepthC));
    issue_pix = can_issue & (cmd_i.mode == MODE_PIXEL);
    gamma_we  = can_issue & (cmd_i.mode == MODE_GAMMA);
    cmd_pop_o = can_issue;

    // back-to-back items on one position see the residue just written
    residue = s1_fwd_q ? last_wr_q : res_rdata;
    sum     = 13'(residue) + 13'(gamma_rdata);

    res_we    = clearing_q | s1_valid_q;
    res_waddr = clearing_q ? clr_idx_q : s1_pos_q;
    res_wdata = clearing_q ? clr_val_q : sum[7:0];

    res_in.level     = sum[11:8];
    res_in.waveform  = expand_level(sum[11:8]);
    res_in.frame_end = s1_last_q;

    clearing_d = clearing_q;
    clr_idx_d  = clr_idx_q;
    clr_val_d  = clr_val_q;
    if (clearing_q) begin
      clr_val_d = clr_val_q + RESIDUE_STEP;
      if (clr_idx_q == LastPos) begin
        clearing_d = 1'b0;
      end else begin
        clr_idx_d = clr_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
      clr_val_q  <= RESIDUE_STEP;
      s1_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
    end else begin
      clearing_q <= clearing_d;
      clr_idx_q  <= clr_idx_d;
      clr_val_q  <= clr_val_d;
      s1_valid_q <= issue_pix;
      s1_fwd_q   <= issue_pix & s1_valid_q & (s1_pos_q == cmd_pos_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_pix) begin
      s1_pos_q  <= cmd_pos_i;
      s1_last_q <= cmd_i.last;
    end
    if (s1_valid_q) begin
      last_wr_q <= sum[7:0];
    end
  end

  lgd_ram #(
    .Width (12),
    .Depth (256)
  ) u_gamma_ram (
    .clk_i   (clk_i),
    .we_i    (gamma_we),
    .waddr_i (cmd_i.pixel),
    .wdata_i (cmd_i.entry),
    .raddr_i (cmd_i.pixel),
    .rdata_o (gamma_rdata)
  );

  lgd_ram #(
    .Width (8),
    .Depth (NUM_BYTES)
  ) u_residue_ram (
    .clk_i   (clk_i),
    .we_i    (res_we),
    .waddr_i (res_waddr),
    .wdata_i (res_wdata),
    .raddr_i (cmd_pos_i),
    .rdata_o (res_rdata)
  );

  lgd_fifo #(
    .Width ($bits(res_t)),
    .Depth (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s1_valid_q),
    .data_i  (res_in),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .data_o  (res_out),
    .empty_o (out_empty),
    .count_o (out_count)
  );

  assign empty_o         = out_empty;
  assign waveform_bits_o = res_out.waveform;
  assign level_o         = res_out.level;
  assign frame_end_o     = res_out.frame_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
    end else if (s1_valid_q && out_full) begin
      $error("result item dropped at full output queue");
    end
  end

endmodule

[hw/rtl/led_gamma_dither_encoder.sv]
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+-------------------------------------
// input     | in        | push_i / full_o            | mode_i, pixel_value_i, gamma_entry_i
// result    | out       | pop_i / empty_o            | waveform_bits_o, level_o, frame_end_o
// config    | in        | cfg_valid_i / cfg_ready_o  | cfg_frame_bytes_i
//
// one item per cycle sustained while results are popped and no residue load runs; a pixel
// item's result goes through the command queue, the gamma and residue ram read and the sum
// into the output queue; after reset full_o stays high while the residue ram is loaded
// a stalled result side backs up through the output queue and then the command queue
module led_gamma_dither_encoder #(
  parameter int unsigned NUM_BYTES = lgd_pkg::NUM_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_frame_bytes_i,
  input  logic        push_i,
  output logic        full_o,
  input  logic        mode_i,
  input  logic [7:0]  pixel_value_i,
  input  logic [11:0] gamma_entry_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [23:0] waveform_bits_o,
  output logic [3:0]  level_o,
  output logic        frame_end_o
);

  import lgd_pkg::*;

  localparam int unsigned PosW = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;
  localparam int unsigned QW   = $bits(cmd_t) + PosW;

  status_t         status;
  cmd_t            cmd_in, cmd_out;
  logic [PosW-1:0] pos_in, pos_out;
  logic            cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;

  lgd_front #(
    .NUM_BYTES (NUM_BYTES)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_frame_bytes_i (cfg_frame_bytes_i),
    .push_i            (push_i),
    .full_o            (full_o),
    .mode_i            (mode_i),
    .pixel_value_i     (pixel_value_i),
    .gamma_entry_i     (gamma_entry_i),
    .status_i          (status),
    .cmd_full_i        (cmd_full),
    .cmd_push_o        (cmd_push),
    .cmd_o             (cmd_in),
    .cmd_pos_o         (pos_in)
  );

  lgd_fifo #(
    .Width (QW),
    .Depth (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  ({cmd_in, pos_in}),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  ({cmd_out, pos_out}),
    .empty_o (cmd_empty),
    .count_o (cmd_count)
  );

  lgd_back #(
    .NUM_BYTES (NUM_BYTES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_empty_i     (cmd_empty),
    .cmd_i           (cmd_out),
    .cmd_pos_i       (pos_out),
    .cmd_pop_o       (cmd_pop),
    .status_o        (status),
    .pop_i           (pop_i),
    .empty_o         (empty_o),
    .waveform_bits_o (waveform_bits_o),
    .level_o         (level_o),
    .frame_end_o     (frame_end_o)
  );

  // nothing may enter while the residue ram is being loaded
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.clearing |-> full_o)
    else $error("input open during residue load");

  a_clear_leaves_queue_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(status.clearing) |-> cmd_empty)
    else $error("item queued during residue load");

  a_accept_reaches_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o) |=> !cmd_empty)
    else $error("accepted item missing from command queue");

  a_pop_only_when_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> (!cmd_empty && cmd_count != '0))
    else $error("back end popped an empty command queue");

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import lgd_pkg::*;

  localparam int unsigned NUM_BYTES      = NUM_BYTES_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 8;

  typedef struct {
    mode_e       mode;
    logic [7:0]  pixel;
    logic [11:0] entry;
    bit          drain_first;
  } byte_item_t;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        cfg_valid_i       = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_frame_bytes_i = '0;
  logic        push_i            = 1'b0;
  logic        full_o;
  logic        mode_i            = 1'b0;
  logic [7:0]  pixel_value_i     = '0;
  logic [11:0] gamma_entry_i     = '0;
  logic        empty_o;
  logic        pop_i             = 1'b0;
  logic [23:0] waveform_bits_o;
  logic [3:0]  level_o;
  logic        frame_end_o;

  // stimulus side
  byte_item_t  pending_bytes[$];
  logic [7:0]  loaded_idx[$];
  bit [255:0]  loaded;
  logic [7:0]  last_written;
  bit          took_item   = 1'b0;
  int unsigned burst_left  = 0;
  int unsigned gap_left    = 0;
  int unsigned stall_tick  = 0;
  int unsigned stall_style = 0;
  int unsigned stall_hold  = 0;

  // predicted block state
  logic [11:0] gamma_model [256];
  logic [7:0]  residue_model [NUM_BYTES];
  int unsigned frame_pos     = 0;
  logic [7:0]  frame_len_cfg = FRAME_BYTES_RESET;
  res_t        expected_symbols[$];
  int unsigned mismatches    = 0;
  int unsigned idle_cycles   = 0;

  led_gamma_dither_encoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_frame_bytes_i(cfg_frame_bytes_i),
    .push_i           (push_i),
    .full_o           (full_o),
    .mode_i           (mode_i),
    .pixel_value_i    (pixel_value_i),
    .gamma_entry_i    (gamma_entry_i),
    .empty_o          (empty_o),
    .pop_i            (pop_i),
    .waveform_bits_o  (waveform_bits_o),
    .level_o          (level_o),
    .frame_end_o      (frame_end_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // sender: bursts of items with random gaps
  always @(negedge clk_i) begin : driver
    byte_item_t cur;
    if (push_i && !took_item) begin
      // item still waiting to be taken
    end else if (gap_left != 0) begin
      push_i   <= 1'b0;
      gap_left  = gap_left - 1;
    end else if (rst_ni && pending_bytes.size() != 0 &&
                 !(pending_bytes[0].drain_first && expected_symbols.size() != 0)) begin
      cur            = pending_bytes.pop_front();
      push_i        <= 1'b1;
      mode_i        <= cur.mode;
      pixel_value_i <= cur.pixel;
      gamma_entry_i <= cur.entry;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left = burst_left - 1;
      end
    end else begin
      push_i <= 1'b0;
    end
  end

  // receiver: pops under one of four stall styles, drawn anew at random
  always @(negedge clk_i) begin : sink
    stall_tick = stall_tick + 1;
    if (stall_tick % 256 == 0) stall_style = $urandom_range(0, 3);
    case (stall_style)
      0: pop_i <= 1'b1;
      1: pop_i <= ($urandom_range(0, 9) >= 3);
      2: pop_i <= ((stall_tick % 7) >= 3);
      default: begin
        if (stall_hold != 0) begin
          pop_i      <= 1'b0;
          stall_hold  = stall_hold - 1;
        end else begin
          pop_i <= 1'b1;
          if ($urandom_range(0, 15) == 0) stall_hold = $urandom_range(1, 20);
        end
      end
    endcase
  end

  always @(posedge clk_i) begin : monitor
    res_t        got;
    res_t        want;
    logic [11:0] sum;
    logic [3:0]  lvl;
    int unsigned span;
    bit          at_end;
    took_item <= push_i && (full_o === 1'b0);
    if (cfg_valid_i && cfg_ready_o === 1'b1) frame_len_cfg = cfg_frame_bytes_i;

    if (pop_i && empty_o === 1'b0) begin
      got.waveform  = waveform_bits_o;
      got.level     = level_o;
      got.frame_end = frame_end_o;
      if (expected_symbols.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: waveform %h level %0d frame_end %0b",
                   got.waveform, got.level, got.frame_end);
      end else begin
        want = expected_symbols.pop_front();
        if (got.waveform !== want.waveform || got.level !== want.level ||
            got.frame_end !== want.frame_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: wave exp %h got %h, level exp %0d got %0d, end exp %0b got %0b",
                     want.waveform, got.waveform, want.level, got.level,
                     want.frame_end, got.frame_end);
        end
      end
    end

    if (push_i && full_o === 1'b0) begin
      if (mode_e'(mode_i) == MODE_GAMMA) begin
        gamma_model[pixel_value_i] = (gamma_entry_i > GAMMA_MAX) ? GAMMA_MAX : gamma_entry_i;
      end else begin
        span = (frame_len_cfg == 0) ? 1 : frame_len_cfg;
        if (span > NUM_BYTES) span = NUM_BYTES;
        sum = residue_model[frame_pos] + gamma_model[pixel_value_i];
        lvl = sum[11:8];
        residue_model[frame_pos] = sum[7:0];
        // a position left beyond a lowered length also ends the frame
        at_end    = (frame_pos + 1 >= span);
        frame_pos = at_end ? 0 : frame_pos + 1;
        want.waveform = SYMBOL_BASE;
        for (int k = 0; k < 4; k++) want.waveform[3*k+1] = lvl[k];
        want.level     = lvl;
        want.frame_end = at_end;
        expected_symbols.push_back(want);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((push_i && full_o === 1'b0) || (pop_i && empty_o === 1'b0) ||
        (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic queue_table_write(input logic [7:0] idx, input logic [11:0] value);
    byte_item_t it;
    it.mode        = MODE_GAMMA;
    it.pixel       = idx;
    it.entry       = value;
    it.drain_first = 1'b0;
    if (!loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_idx.push_back(idx);
    end
    last_written = idx;
    pending_bytes.push_back(it);
  endtask

  task automatic queue_pixel(input logic [7:0] idx, input bit drain);
    byte_item_t it;
    it.mode        = MODE_PIXEL;
    it.pixel       = idx;
    it.entry       = 12'($urandom_range(0, 4095));
    it.drain_first = drain;
    pending_bytes.push_back(it);
  endtask

  // pixels only read table entries that have been loaded
  task automatic queue_random_mix(input int unsigned n_pix);
    int unsigned done_pix;
    logic [11:0] value;
    logic [7:0]  idx;
    done_pix = 0;
    while (done_pix < n_pix) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 9))
          0:       value = '0;
          1:       value = GAMMA_MAX;
          2:       value = 12'($urandom_range(GAMMA_MAX + 1, 4095));
          default: value = 12'($urandom_range(0, 4095));
        endcase
        queue_table_write(8'($urandom_range(0, 255)), value);
      end else begin
        if ($urandom_range(0, 9) == 0) idx = last_written;
        else idx = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
        queue_pixel(idx, $urandom_range(0, 199) == 0);
        done_pix++;
      end
    end
  endtask

  task automatic settle();
    // look just after the edge, once the driver and the monitor have both moved
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_bytes.size() != 0 || push_i || expected_symbols.size() != 0);
    while (expected_symbols.size() != 0) @(negedge clk_i);
    // table writes leave no result behind, so give the pipeline time to empty
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_frame_len(input logic [7:0] value);
    @(negedge clk_i);
    cfg_frame_bytes_i <= value;
    cfg_valid_i       <= 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NUM_BYTES; i++) residue_model[i] = 8'((i + 1) * RESIDUE_STEP);
    for (int i = 0; i < 256; i++) gamma_model[i] = '0;
    loaded        = '0;
    last_written  = '0;

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // table extremes, clamping, and a read right behind a rewrite
    queue_table_write(8'd0,   12'd0);
    queue_table_write(8'd255, GAMMA_MAX);
    queue_table_write(8'd1,   12'd4095);
    queue_table_write(8'd128, GAMMA_MAX + 12'd1);
    queue_table_write(8'h55,  12'hAAA);
    queue_table_write(8'hAA,  12'h555);
    queue_table_write(8'd2,   12'd256);
    queue_table_write(8'd3,   GAMMA_MAX - 12'd1);
    queue_pixel(8'd0,   1'b0);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd1,   1'b0);
    queue_pixel(8'd128, 1'b0);
    queue_pixel(8'h55,  1'b0);
    queue_pixel(8'hAA,  1'b0);
    queue_pixel(8'd2,   1'b0);
    queue_pixel(8'd3,   1'b0);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd255, 1'b0);
    queue_table_write(8'd3, 12'd1000);
    queue_pixel(8'd3, 1'b0);
    queue_pixel(8'd1, 1'b1);
    queue_pixel(8'd0, 1'b0);
    queue_random_mix(200);
    settle();

    set_frame_len(8'd1);
    queue_random_mix(150);
    settle();

    // leaves the position at 300 mod 128 for the shortened frame that follows
    set_frame_len(8'd128);
    queue_random_mix(300);
    settle();

    set_frame_len(8'd5);
    queue_random_mix(100);
    settle();

    set_frame_len(8'd0);
    queue_random_mix(100);
    settle();

    set_frame_len(8'd255);
    queue_random_mix(200);
    settle();

    set_frame_len(8'($urandom_range(2, 127)));
    queue_random_mix(150);
    settle();

    set_frame_len(8'($urandom_range(129, 254)));
    queue_random_mix(100);
    settle();

    if (mismatches == 0 && expected_symbols.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/lgd_pkg.sv
hw/rtl/lgd_ram.sv
hw/rtl/lgd_fifo.sv
hw/rtl/lgd_front.sv
hw/rtl/lgd_back.sv
hw/rtl/led_gamma_dither_encoder.sv
dv/testbench.sv
